[rtl/isc_pkg.sv]
// ----------------------------------------------------------------------------
// isc_pkg
// Shared types and constants for the insertion sorter with compare count.
// ----------------------------------------------------------------------------
package isc_pkg;

  localparam int VALUE_W   = 32;
  localparam int COMPARE_W = 11;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      is_final;
  } isc_in_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0]   sorted_value;
    logic        [COMPARE_W-1:0] compare_total;
    logic                        overflowed;
    logic                        end_of_run;
  } isc_out_t;

  // Control broadcast to every cell of the chain.
  typedef struct packed {
    logic insert;
    logic shift_left;
  } isc_cell_ctl_t;

endpackage

[rtl/insertion_sort_with_compare_count_unit.sv]
// ----------------------------------------------------------------------------
// insertion_sort_with_compare_count_unit
// Systolic insertion sorter that also counts insertion-sort comparisons.
// ----------------------------------------------------------------------------
//
//  Channel  | Signals                            | Payload
//  ---------+------------------------------------+---------------------------
//  input    | item_valid, item_stall, item       | value, is_final
//  output   | result_valid, result_stall, result | sorted_value, compare_total,
//           |                                    | overflowed, end_of_run
//
// While a run is being collected the block takes one item every cycle: each
// cell of the chain compares its value with the new one in parallel and the
// whole insertion is one parallel shift of the chain. After the final item
// the block passes through a settle state that lets the comparison total
// settle, then emits one sorted result per cycle while the output is not
// stalled, by shifting the chain toward cell zero. The input is stalled from
// the final item until the last result is loaded.
// Reset empties the chain and clears the total and overflow flag.
// ----------------------------------------------------------------------------
module insertion_sort_with_compare_count_unit
  import isc_pkg::*;
#(
  parameter int CAPACITY = 64
)(
  input  logic     clk,
  input  logic     rst,
  input  logic     item_valid,
  output logic     item_stall,
  input  isc_in_t  item,
  output logic     result_valid,
  input  logic     result_stall,
  output isc_out_t result
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);

  // Collecting a run, waiting for the total to settle, emitting the run.
  typedef enum logic [2:0] {
    ST_FILL   = 3'b001,
    ST_SETTLE = 3'b010,
    ST_DRAIN  = 3'b100
  } state_t;

  state_t state, state_next;

  logic                       accept;
  logic                       full;
  logic                       load;
  isc_cell_ctl_t              ctl;

  logic signed [VALUE_W-1:0]  cell_value [CAPACITY];
  logic [CAPACITY-1:0]        cell_occ;
  logic [CAPACITY-1:0]        cell_gt;

  logic [CNT_W-1:0]           fill_count;
  logic [COMPARE_W-1:0]       compare_sum;
  logic                       drop_flag;
  logic [CNT_W-1:0]           inc;
  logic                       inc_valid;

  logic [IDX_W-1:0]           pos_enc;
  logic                       any_gt;
  logic [CNT_W-1:0]           pos_full;
  logic [CNT_W-1:0]           greater;
  logic                       last_load;

  assign item_stall = (state != ST_FILL);
  assign accept     = item_valid && !item_stall;
  assign full       = (fill_count == CNT_W'(CAPACITY));
  assign load       = (state == ST_DRAIN) && (!result_valid || !result_stall);
  assign last_load  = load && ((CAPACITY < 2) || !cell_occ[1]);

  assign ctl.insert     = accept && !full;
  assign ctl.shift_left = load;

  // The chain of cells. Cell zero sees an occupied, never-greater left side.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [VALUE_W-1:0] lv, rv;
    logic                      lo, lg, ro;
    if (i == 0) begin : g_first
      assign lv = item.value;
      assign lo = 1'b1;
      assign lg = 1'b0;
    end else begin : g_mid
      assign lv = cell_value[i-1];
      assign lo = cell_occ[i-1];
      assign lg = cell_gt[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign rv = cell_value[i];
      assign ro = 1'b0;
    end else begin : g_inner
      assign rv = cell_value[i+1];
      assign ro = cell_occ[i+1];
    end
    isc_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl),
      .new_value   (item.value),
      .left_value  (lv),
      .left_occ    (lo),
      .left_gt     (lg),
      .right_value (rv),
      .right_occ   (ro),
      .value       (cell_value[i]),
      .occ         (cell_occ[i]),
      .gt          (cell_gt[i])
    );
  end

  // The greater-than flags form a contiguous run at the top of the occupied
  // cells, so the insert position is the one cell where that run begins.
  always_comb begin
    pos_enc = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (cell_gt[i] && (i == 0 || !cell_gt[(i == 0) ? 0 : i - 1])) begin
        pos_enc = pos_enc | IDX_W'(i);
      end
    end
  end

  assign any_gt   = |cell_gt;
  assign pos_full = any_gt ? CNT_W'(pos_enc) : fill_count;
  assign greater  = fill_count - pos_full;

  always_comb begin
    state_next = state;
    case (state)
      ST_FILL:   if (accept && item.is_final) state_next = ST_SETTLE;
      ST_SETTLE: state_next = ST_DRAIN;
      ST_DRAIN:  if (last_load) state_next = ST_FILL;
      default:   state_next = ST_FILL;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_FILL;
    end else begin
      state <= state_next;
    end
  end

  // Run bookkeeping. The increment for an insertion is registered and added
  // in the following cycle, which the settle state covers for the final item.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count  <= '0;
      compare_sum <= '0;
      drop_flag   <= 1'b0;
      inc_valid   <= 1'b0;
    end else begin
      inc_valid <= ctl.insert;
      if (last_load) begin
        fill_count  <= '0;
        compare_sum <= '0;
        drop_flag   <= 1'b0;
      end else begin
        if (ctl.insert) begin
          fill_count <= fill_count + CNT_W'(1);
        end
        if (accept && full) begin
          drop_flag <= 1'b1;
        end
        if (inc_valid) begin
          compare_sum <= compare_sum + COMPARE_W'(inc);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.insert) begin
      inc <= greater + CNT_W'(pos_full != '0);
    end
  end

  // Output register, fed from cell zero as the chain shifts down.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result.sorted_value  <= cell_value[0];
      result.compare_total <= compare_sum;
      result.overflowed    <= drop_flag;
      result.end_of_run    <= last_load;
    end
  end

endmodule

[rtl/isc_cell.sv]
// ----------------------------------------------------------------------------
// isc_cell
// One cell of the sorting chain: holds one value and its occupied flag.
// ----------------------------------------------------------------------------
module isc_cell
  import isc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  isc_cell_ctl_t             ctl,
  input  logic signed [VALUE_W-1:0] new_value,
  input  logic signed [VALUE_W-1:0] left_value,
  input  logic                      left_occ,
  input  logic                      left_gt,
  input  logic signed [VALUE_W-1:0] right_value,
  input  logic                      right_occ,
  output logic signed [VALUE_W-1:0] value,
  output logic                      occ,
  output logic                      gt
);

  logic take;

  // A stored value strictly greater than the new one moves right.
  assign gt   = occ && (value > new_value);
  // The first empty cell also takes part in an insertion.
  assign take = gt || (!occ && left_occ);

  always_ff @(posedge clk) begin
    if (ctl.insert && take) begin
      value <= left_gt ? left_value : new_value;
    end else if (ctl.shift_left) begin
      value <= right_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 1'b0;
    end else if (ctl.insert && take) begin
      occ <= 1'b1;
    end else if (ctl.shift_left) begin
      occ <= right_occ;
    end
  end

endmodule

[rtl/isc_checker.sv]
// ----------------------------------------------------------------------------
// isc_checker
// Port-level checks for the insertion sorter, bound to the top level.
// ----------------------------------------------------------------------------
module isc_checker
  import isc_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     item_valid,
  input logic     item_stall,
  input isc_in_t  item,
  input logic     result_valid,
  input logic     result_stall,
  input isc_out_t result
);

  // A stalled result holds.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed");

  // A final item that is taken closes the input.
  a_final_stalls: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && item.is_final |=> item_stall)
    else $error("input open right after final item");

  // No new item may be taken while a run is still being emitted.
  a_drain_stalls: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.end_of_run |-> item_stall)
    else $error("input open during run output");

  // Within a run the next result follows at once with the same total and flag.
  a_run_constant: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_stall && !result.end_of_run |=>
      result_valid &&
      result.compare_total == $past(result.compare_total) &&
      result.overflowed == $past(result.overflowed))
    else $error("run summary changed within run");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

endmodule

bind insertion_sort_with_compare_count_unit isc_checker u_isc_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .item         (item),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

[verif/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for insertion_sort_with_compare_count_unit. A short
// table of directed runs (extremes, equal values, ordered input) is followed
// by random runs of mixed length. Runs include a completely full store, a
// strictly descending full store for the largest comparison total, and
// overflowing runs. Each accepted item updates a behavioral copy of the
// sorted store. The emitted runs are checked field by field in order, with
// random idling on both channels.
// ----------------------------------------------------------------------------
module tb;
  import isc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAP          = 64;
  localparam int RANDOM_ITEMS = 410;
  localparam int IDLE_PCT     = 27;
  localparam int STALL_LIMIT  = 2000;
  localparam int TAIL_CYCLES  = 16;
  localparam int NUM_DIRECTED = 20;

  localparam logic signed [VALUE_W-1:0] MIN_V = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] MAX_V = 32'sh7FFF_FFFF;

  // One item to send. Rows with typed set carry their single expected result;
  // drain_first holds the item back until every pending result has arrived.
  typedef struct packed {
    isc_in_t  item;
    logic     typed;
    isc_out_t want;
    logic     drain_first;
  } stim_row_t;

  // Single-element runs have results that follow directly: the value itself,
  // no comparisons, no overflow, end of run. Longer runs go to the model.
  localparam stim_row_t DIRECTED [NUM_DIRECTED] = '{
    '{'{MIN_V, 1'b1},  1'b1, '{MIN_V, 11'd0, 1'b0, 1'b1},  1'b0},
    '{'{MAX_V, 1'b1},  1'b1, '{MAX_V, 11'd0, 1'b0, 1'b1},  1'b0},
    '{'{32'sd0, 1'b1}, 1'b1, '{32'sd0, 11'd0, 1'b0, 1'b1}, 1'b0},
    '{'{-32'sd1, 1'b1}, 1'b1, '{-32'sd1, 11'd0, 1'b0, 1'b1}, 1'b0},
    '{'{32'sd1, 1'b1}, 1'b1, '{32'sd1, 11'd0, 1'b0, 1'b1}, 1'b0},
    // Mixed run with repeated values and both extremes.
    '{'{32'sd7, 1'b0},  1'b0, '0, 1'b1},
    '{'{-32'sd7, 1'b0}, 1'b0, '0, 1'b0},
    '{'{32'sd7, 1'b0},  1'b0, '0, 1'b0},
    '{'{MAX_V, 1'b0},   1'b0, '0, 1'b0},
    '{'{MIN_V, 1'b0},   1'b0, '0, 1'b0},
    '{'{32'sd0, 1'b0},  1'b0, '0, 1'b0},
    '{'{-32'sd1, 1'b0}, 1'b0, '0, 1'b0},
    '{'{32'sd7, 1'b1},  1'b0, '0, 1'b0},
    // Descending input: every earlier element is greater.
    '{'{32'sd3, 1'b0},  1'b0, '0, 1'b0},
    '{'{32'sd2, 1'b0},  1'b0, '0, 1'b0},
    '{'{32'sd1, 1'b0},  1'b0, '0, 1'b0},
    '{'{32'sd0, 1'b1},  1'b0, '0, 1'b0},
    // Ascending input: one comparison per element after the first.
    '{'{32'sd1, 1'b0},  1'b0, '0, 1'b0},
    '{'{32'sd2, 1'b0},  1'b0, '0, 1'b0},
    '{'{32'sd3, 1'b1},  1'b0, '0, 1'b0}
  };

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     item_valid = 1'b0;
  logic     item_stall;
  isc_in_t  item = '0;
  logic     result_valid;
  logic     result_stall = 1'b0;
  isc_out_t result;

  insertion_sort_with_compare_count_unit #(.CAPACITY(CAP)) uut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Behavioral copy of the sorted store and the run totals.
  logic signed [VALUE_W-1:0] held_cells [CAP];
  int                        held_count = 0;
  logic [11:0]               compare_sum = '0;
  logic                      drop_seen = 1'b0;

  isc_out_t  pending_sorted [$];
  stim_row_t stim [$];
  int        items_taken = 0;
  int        mismatches = 0;
  int        idle_cycles = 0;
  logic      quiet_window;

  // No idling on either side while this stretch of items goes through.
  assign quiet_window = (items_taken >= 150) && (items_taken < 260);

  // Inserts one value after every stored value not greater than it and adds
  // its insertion-sort comparisons. On a final item the whole sorted run is
  // queued as expected results (unless the row supplies its own) and the
  // store is emptied.
  function automatic void sort_and_emit(input isc_in_t it, input bit emit);
    logic signed [VALUE_W-1:0] v;
    int       greater;
    int       slot;
    isc_out_t r;
    v = it.value;
    if (held_count < CAP) begin
      greater = 0;
      for (int i = 0; i < held_count; i++) begin
        if (held_cells[i] > v) greater++;
      end
      slot = held_count - greater;
      compare_sum = compare_sum + 12'(greater) + ((slot > 0) ? 12'd1 : 12'd0);
      for (int i = held_count; i > slot; i--) held_cells[i] = held_cells[i-1];
      held_cells[slot] = v;
      held_count++;
    end else begin
      drop_seen = 1'b1;
    end
    if (!it.is_final) return;
    if (emit) begin
      for (int k = 0; k < held_count; k++) begin
        r.sorted_value  = held_cells[k];
        r.compare_total = compare_sum[COMPARE_W-1:0];
        r.overflowed    = drop_seen;
        r.end_of_run    = (k == held_count - 1);
        pending_sorted.push_back(r);
      end
    end
    held_count  = 0;
    compare_sum = '0;
    drop_seen   = 1'b0;
  endfunction

  function automatic void push_item(input logic signed [VALUE_W-1:0] v, input bit last,
                                    input bit drain);
    stim_row_t row;
    row             = '0;
    row.item.value    = v;
    row.item.is_final = last;
    row.drain_first   = drain;
    stim.push_back(row);
  endfunction

  // Mostly full-range values, with extremes and a narrow band that gives
  // plenty of equal values.
  function automatic logic signed [VALUE_W-1:0] rand_value();
    case ($urandom_range(9))
      0:       return MIN_V;
      1:       return MAX_V;
      2, 3:    return $signed($urandom_range(16)) - 32'sd8;
      default: return $signed($urandom());
    endcase
  endfunction

  function automatic void add_random_runs();
    int                        run_idx;
    int                        len;
    int                        pick;
    logic signed [VALUE_W-1:0] v;
    run_idx = 0;
    while (stim.size() < NUM_DIRECTED + RANDOM_ITEMS) begin
      pick = (run_idx == 0) ? 0 : (run_idx == 1) ? 5 : $urandom_range(99);
      if (pick >= 5 && pick < 9) begin
        // Strictly descending full store: the largest comparison total.
        v = MAX_V - $signed($urandom_range(1000));
        for (int k = 0; k < CAP; k++) begin
          push_item(v, k == CAP - 1, 1'b0);
          v = v - $signed($urandom_range(1 << 20, 1));
        end
      end else begin
        if (pick < 5)       len = CAP + $urandom_range(4, 1);  // overflows
        else if (pick < 12) len = CAP;                         // exactly full
        else if (pick < 20) len = $urandom_range(40, 13);
        else                len = $urandom_range(10, 1);
        for (int k = 0; k < len; k++) begin
          // The first random item waits for the directed results to drain.
          push_item(rand_value(), k == len - 1, run_idx == 0 && k == 0);
        end
      end
      run_idx++;
    end
  endfunction

  task automatic check_result(input isc_out_t got);
    isc_out_t want;
    if (pending_sorted.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result: value %0d total %0d overflowed %0b end %0b",
                 got.sorted_value, got.compare_total, got.overflowed, got.end_of_run);
    end else begin
      want = pending_sorted.pop_front();
      if (got.sorted_value !== want.sorted_value || got.compare_total !== want.compare_total ||
          got.overflowed !== want.overflowed || got.end_of_run !== want.end_of_run) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch: expected %0d/%0d/%0b/%0b got %0d/%0d/%0b/%0b",
                   want.sorted_value, want.compare_total, want.overflowed, want.end_of_run,
                   got.sorted_value, got.compare_total, got.overflowed, got.end_of_run);
      end
    end
  endtask

  // Receiving side: checks each accepted result and stalls at random.
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) check_result(result);
      result_stall <= !quiet_window && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // Ends the run if neither channel moves for too long.
  always @(posedge clk) begin
    if (!rst) begin
      if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("** insertion_sort_with_compare_count_unit: FAILED **");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Sending side: builds the stimulus, releases reset and walks the list.
  initial begin : sender
    int pos;
    for (int i = 0; i < NUM_DIRECTED; i++) stim.push_back(DIRECTED[i]);
    add_random_runs();

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    pos = 0;
    while (pos < stim.size()) begin
      @(posedge clk);
      if (item_valid && !item_stall) begin
        sort_and_emit(stim[pos].item, !stim[pos].typed);
        if (stim[pos].typed) pending_sorted.push_back(stim[pos].want);
        pos++;
        items_taken = pos;
      end
      // A stalled item stays on the bus unchanged.
      if (!(item_valid && item_stall)) begin
        if (pos < stim.size() &&
            !(stim[pos].drain_first && pending_sorted.size() != 0) &&
            (quiet_window || $urandom_range(99) >= IDLE_PCT)) begin
          item_valid <= 1'b1;
          item       <= stim[pos].item;
        end else begin
          item_valid <= 1'b0;
        end
      end
    end

    while (pending_sorted.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("** insertion_sort_with_compare_count_unit: PASSED **");
    end else begin
      $display("** insertion_sort_with_compare_count_unit: FAILED **");
    end
    $finish;
  end

endmodule

[insertion_sort_with_compare_count_unit.f]
rtl/isc_pkg.sv
rtl/isc_cell.sv
rtl/insertion_sort_with_compare_count_unit.sv
rtl/isc_checker.sv
verif/tb.sv
